@@ hdl/packet_delay_drop_emulator_macros.svh @@
// Assertion macros shared by the packet delay and drop emulator.
`ifndef PACKET_DELAY_DROP_EMULATOR_MACROS_SVH
`define PACKET_DELAY_DROP_EMULATOR_MACROS_SVH

// Checks that a condition implies a consequence in the same cycle.
`define PDDE_IMPLIES(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Checks that a condition implies a consequence in the next cycle.
`define PDDE_NEXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/pdde_pkg.sv @@
// Package with types and constants of the packet delay and drop emulator.
`default_nettype none
package pdde_pkg;

  localparam int IN_TDATA_W  = 128;
  localparam int OUT_TDATA_W = 72;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;
  localparam int RAND_W      = 16;
  localparam int TICK_W      = 24;
  localparam int COUNT_W     = 7;

  localparam logic [1:0] ST_RELEASED = 2'd0;
  localparam logic [1:0] ST_QUEUED   = 2'd1;
  localparam logic [1:0] ST_DROPPED  = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_DROP_EN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LAT_EN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DROP_RATIO = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LATENCY    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_JITTER     = 3'd4;

  typedef struct packed {
    logic [15:0] handle;
    logic [31:0] addr;
    logic [15:0] port;
  } payload_t;

  typedef struct packed {
    logic ins;
    logic pop;
  } cell_ctl_t;

endpackage
`default_nettype wire

@@ hdl/pdde_cell.sv @@
// One cell of the time-sorted pending chain.
`default_nettype none
module pdde_cell #(
  parameter int TIME_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire pdde_pkg::cell_ctl_t   ctl,
  input  wire logic [TIME_BITS-1:0]  new_time,
  input  wire pdde_pkg::payload_t    new_pay,
  input  wire logic                  left_valid,
  input  wire logic [TIME_BITS-1:0]  left_time,
  input  wire pdde_pkg::payload_t    left_pay,
  input  wire logic                  right_valid,
  input  wire logic [TIME_BITS-1:0]  right_time,
  input  wire pdde_pkg::payload_t    right_pay,
  input  wire logic                  found_in,
  output logic                       found_out,
  output logic                       valid,
  output logic [TIME_BITS-1:0]       slot_time,
  output pdde_pkg::payload_t         slot_pay
);
  import pdde_pkg::*;

  logic                 valid_r, valid_nxt;
  logic [TIME_BITS-1:0] time_r, time_nxt;
  payload_t             pay_r, pay_nxt;
  logic [TIME_BITS-1:0] diff;
  logic                 later;
  logic                 mark;

  // The stored entry is later than the new one when new minus stored is negative.
  assign diff      = new_time - time_r;
  assign later     = valid_r && diff[TIME_BITS-1];
  assign mark      = later || !valid_r;
  assign found_out = found_in || mark;

  always_comb begin
    valid_nxt = valid_r;
    time_nxt  = time_r;
    pay_nxt   = pay_r;
    priority if (ctl.pop) begin
      valid_nxt = right_valid;
      time_nxt  = right_time;
      pay_nxt   = right_pay;
    end else if (ctl.ins && found_in) begin
      valid_nxt = left_valid;
      time_nxt  = left_time;
      pay_nxt   = left_pay;
    end else if (ctl.ins && mark) begin
      valid_nxt = 1'b1;
      time_nxt  = new_time;
      pay_nxt   = new_pay;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    time_r <= time_nxt;
    pay_r  <= pay_nxt;
  end

  assign valid     = valid_r;
  assign slot_time = time_r;
  assign slot_pay  = pay_r;

endmodule
`default_nettype wire

@@ hdl/packet_delay_drop_emulator.sv @@
// Top level of the packet delay and drop emulator with its sorted cell chain.
//
// Packet arrivals are dropped, refused when the pool is full, or filed in a
// chain of DEPTH cells kept sorted by release time, equal times in arrival
// order. An arrival goes through three steps: operand capture with the
// jitter multiplier, the release-time add, and one insert step, held while
// the output is stalled, in which every cell compares its time with the new
// one and the chain shifts in parallel. A release check shifts one due entry
// out of the chain head per cycle while the output is not stalled, and goes
// back to idle with no output when nothing is due.
// The input side is ready whenever the block is idle, even while the last
// result still waits in the output register. No clearing pass follows reset.
`default_nettype none
module packet_delay_drop_emulator #(
  parameter int DEPTH     = 64,
  parameter int TIME_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // now, rand_drop, rand_jitter, packet_handle, source_addr, source_port
  input  wire logic [pdde_pkg::IN_TDATA_W-1:0]   in_tdata,
  // kind
  input  wire logic                              in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // out_handle, out_addr, out_port, pending_count, one zero pad bit
  output logic [pdde_pkg::OUT_TDATA_W-1:0]       out_tdata,
  // status
  output logic [1:0]                             out_tuser,
  output logic                                   out_tlast,
  input  wire logic                              cfg_we,
  input  wire logic [pdde_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [pdde_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import pdde_pkg::*;
  `include "packet_delay_drop_emulator_macros.svh"

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = TICK_W + RAND_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CALC = 4'b0010,
    S_INS  = 4'b0100,
    S_REL  = 4'b1000
  } state_t;

  state_t               state_r, state_nxt;
  logic                 drop_en_r, drop_en_nxt;
  logic                 lat_en_r, lat_en_nxt;
  logic [RAND_W-1:0]    ratio_r, ratio_nxt;
  logic [TICK_W-1:0]    lat_r, lat_nxt;
  logic [TICK_W-1:0]    jit_r, jit_nxt;
  logic [CW-1:0]        pending_r, pending_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic [TIME_BITS-1:0] now_r, now_nxt;
  logic [RAND_W-1:0]    rdrop_r, rdrop_nxt;
  payload_t             pay_r, pay_nxt;
  logic [PW-1:0]        prod_r, prod_nxt;
  logic [TIME_BITS-1:0] base_r, base_nxt;
  logic [TIME_BITS-1:0] t_r, t_nxt;
  logic [1:0]           status_r, status_nxt;
  payload_t             opay_r, opay_nxt;
  logic [CW-1:0]        ocount_r, ocount_nxt;
  logic                 olast_r, olast_nxt;

  logic                 in_fire;
  logic                 out_free;
  logic                 full;
  logic                 dropped;
  cell_ctl_t            ctl;
  payload_t             in_pay;
  logic [TIME_BITS-1:0] diff0, diff1;
  logic                 due0, due1;

  logic [DEPTH-1:0]     cell_valid;
  logic [TIME_BITS-1:0] cell_time [DEPTH];
  payload_t             cell_pay [DEPTH];
  logic [DEPTH:0]       found;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign full      = (pending_r == CW'(DEPTH));
  assign dropped   = drop_en_r && !(rdrop_r > ratio_r);

  assign in_pay.handle = in_tdata[79:64];
  assign in_pay.addr   = in_tdata[111:80];
  assign in_pay.port   = in_tdata[127:112];

  assign diff0 = now_r - cell_time[0];
  assign diff1 = now_r - cell_time[1];
  assign due0  = cell_valid[0] && !diff0[TIME_BITS-1];
  assign due1  = cell_valid[1] && !diff1[TIME_BITS-1];

  always_comb begin
    drop_en_nxt = drop_en_r;
    lat_en_nxt  = lat_en_r;
    ratio_nxt   = ratio_r;
    lat_nxt     = lat_r;
    jit_nxt     = jit_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_DROP_EN:    drop_en_nxt = cfg_wdata[0];
        REG_LAT_EN:     lat_en_nxt  = cfg_wdata[0];
        REG_DROP_RATIO: ratio_nxt   = cfg_wdata[RAND_W-1:0];
        REG_LATENCY:    lat_nxt     = cfg_wdata[TICK_W-1:0];
        REG_JITTER:     jit_nxt     = cfg_wdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    pending_nxt   = pending_r;
    out_valid_nxt = out_valid_r && !out_tready;
    now_nxt       = now_r;
    rdrop_nxt     = rdrop_r;
    pay_nxt       = pay_r;
    prod_nxt      = prod_r;
    base_nxt      = base_r;
    t_nxt         = t_r;
    status_nxt    = status_r;
    opay_nxt      = opay_r;
    ocount_nxt    = ocount_r;
    olast_nxt     = olast_r;
    ctl           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          now_nxt   = TIME_BITS'(in_tdata[31:0]);
          rdrop_nxt = in_tdata[47:32];
          pay_nxt   = in_pay;
          prod_nxt  = PW'(jit_r) * PW'(in_tdata[63:48]);
          base_nxt  = TIME_BITS'(in_tdata[31:0]) + TIME_BITS'(lat_r) - TIME_BITS'(jit_r);
          state_nxt = in_tuser ? S_REL : S_CALC;
        end
      end
      S_CALC: begin
        t_nxt     = lat_en_r ? base_r + TIME_BITS'(prod_r >> (FRAC_BITS - 1)) : now_r;
        state_nxt = S_INS;
      end
      S_INS: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          opay_nxt      = pay_r;
          olast_nxt     = 1'b1;
          ocount_nxt    = pending_r;
          priority if (dropped) begin
            status_nxt = ST_DROPPED;
          end else if (full) begin
            status_nxt = ST_FULL;
          end else begin
            status_nxt  = ST_QUEUED;
            ctl.ins     = 1'b1;
            pending_nxt = pending_r + 1'b1;
            ocount_nxt  = pending_r + 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      S_REL: begin
        if (!due0) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          ctl.pop       = 1'b1;
          pending_nxt   = pending_r - 1'b1;
          out_valid_nxt = 1'b1;
          status_nxt    = ST_RELEASED;
          opay_nxt      = cell_pay[0];
          ocount_nxt    = pending_r - 1'b1;
          olast_nxt     = !due1;
          if (!due1) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pending_r   <= '0;
      out_valid_r <= 1'b0;
      drop_en_r   <= 1'b0;
      lat_en_r    <= 1'b0;
      ratio_r     <= RAND_W'(655);
      lat_r       <= TICK_W'(70);
      jit_r       <= TICK_W'(30);
    end else begin
      state_r     <= state_nxt;
      pending_r   <= pending_nxt;
      out_valid_r <= out_valid_nxt;
      drop_en_r   <= drop_en_nxt;
      lat_en_r    <= lat_en_nxt;
      ratio_r     <= ratio_nxt;
      lat_r       <= lat_nxt;
      jit_r       <= jit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r    <= now_nxt;
    rdrop_r  <= rdrop_nxt;
    pay_r    <= pay_nxt;
    prod_r   <= prod_nxt;
    base_r   <= base_nxt;
    t_r      <= t_nxt;
    status_r <= status_nxt;
    opay_r   <= opay_nxt;
    ocount_r <= ocount_nxt;
    olast_r  <= olast_nxt;
  end

  assign found[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                 lv, rv;
    logic [TIME_BITS-1:0] lt, rt;
    payload_t             lp, rp;

    if (i == 0) begin : g_head
      assign lv = 1'b0;
      assign lt = '0;
      assign lp = '0;
    end else begin : g_left
      assign lv = cell_valid[i-1];
      assign lt = cell_time[i-1];
      assign lp = cell_pay[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign rv = 1'b0;
      assign rt = '0;
      assign rp = '0;
    end else begin : g_right
      assign rv = cell_valid[i+1];
      assign rt = cell_time[i+1];
      assign rp = cell_pay[i+1];
    end

    pdde_cell #(
      .TIME_BITS (TIME_BITS)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .new_time    (t_r),
      .new_pay     (pay_r),
      .left_valid  (lv),
      .left_time   (lt),
      .left_pay    (lp),
      .right_valid (rv),
      .right_time  (rt),
      .right_pay   (rp),
      .found_in    (found[i]),
      .found_out   (found[i+1]),
      .valid       (cell_valid[i]),
      .slot_time   (cell_time[i]),
      .slot_pay    (cell_pay[i])
    );
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tlast  = olast_r;
  assign out_tdata  = {1'b0, COUNT_W'(ocount_r), opay_r.port, opay_r.addr, opay_r.handle};

  `PDDE_IMPLIES(a_count_match, clk, rst_n, 1'b1, $countones(cell_valid) == int'(pending_r), "bad count")
  `PDDE_IMPLIES(a_ins_not_full, clk, rst_n, ctl.ins, !full, "insert into a full chain")
  `PDDE_IMPLIES(a_pop_due, clk, rst_n, ctl.pop, due0, "head popped while not due")
  `PDDE_NEXT(a_pop_count, clk, rst_n, ctl.pop, pending_r == $past(pending_r) - 1'b1, "pop count off")

endmodule
`default_nettype wire
